@@ rtl/core/pli_pkg.sv @@
// shared types and codes for the positional list block
`default_nettype none

package pli_pkg;

  // widths sized for the largest supported list depth (64)
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;

  localparam logic [1:0] OP_INS_BEFORE = 2'd0;
  localparam logic [1:0] OP_INS_AFTER  = 2'd1;
  localparam logic [1:0] OP_DELETE     = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [1:0] K_SHOW = 2'd0;
  localparam logic [1:0] K_INS  = 2'd1;
  localparam logic [1:0] K_DEL  = 2'd2;
  localparam logic [1:0] K_ERR  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic [31:0]       value;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pli_front.sv @@
// front end: takes requests, checks them against the tracked count, issues commands
`default_nettype none

module pli_front #(
  parameter int DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          opcode,
  input  wire  signed [31:0]  value,
  input  wire  [4:0]          position,
  input  wire                 q_full,
  output logic                push,
  output pli_pkg::cmd_t       push_cmd
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic [PW-1:0] slot;
  logic          bad;
  logic [1:0]    kind;
  logic [1:0]    status;

  assign in_ready = ~q_full;
  assign push     = in_valid & in_ready;

  always_comb begin
    pos_x    = PW'(position);
    cnt_x    = PW'(cnt);
    bad      = (pos_x == '0) || (pos_x > cnt_x);
    kind     = pli_pkg::K_SHOW;
    status   = pli_pkg::ST_OK;
    slot     = '0;
    cnt_next = cnt;
    case (opcode)
      pli_pkg::OP_DELETE: begin
        if (cnt == '0) begin
          kind   = pli_pkg::K_ERR;
          status = pli_pkg::ST_EMPTY;
        end else if (bad) begin
          kind   = pli_pkg::K_ERR;
          status = pli_pkg::ST_BADPOS;
        end else begin
          kind     = pli_pkg::K_DEL;
          slot     = pos_x - PW'(1);
          cnt_next = cnt - CW'(1);
        end
      end
      pli_pkg::OP_INS_BEFORE, pli_pkg::OP_INS_AFTER: begin
        if (cnt >= CW'(DEPTH)) begin
          kind   = pli_pkg::K_ERR;
          status = pli_pkg::ST_FULL;
        end else if (cnt == '0) begin
          // first value goes to the head whatever the position
          kind     = pli_pkg::K_INS;
          cnt_next = cnt + CW'(1);
        end else if (bad) begin
          kind   = pli_pkg::K_ERR;
          status = pli_pkg::ST_BADPOS;
        end else begin
          kind     = pli_pkg::K_INS;
          slot     = (opcode == pli_pkg::OP_INS_BEFORE) ? pos_x - PW'(1) : pos_x;
          cnt_next = cnt + CW'(1);
        end
      end
      default: begin
        kind = pli_pkg::K_SHOW;
      end
    endcase
  end

  always_comb begin
    push_cmd.kind   = kind;
    push_cmd.status = status;
    push_cmd.slot   = pli_pkg::SLOT_W'(slot);
    push_cmd.count  = pli_pkg::CNT_W'(cnt_next);
    push_cmd.value  = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pli_queue.sv @@
// two-entry command queue between front and back
`default_nettype none

module pli_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  pli_pkg::cmd_t  push_cmd,
  output logic           full,
  input  wire            pop,
  output logic           q_valid,
  output pli_pkg::cmd_t  q_cmd
);

  pli_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pli_back.sv @@
// back end: shift-array list store, update and element emission
`default_nettype none

module pli_back #(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  pli_pkg::cmd_t      q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         status,
  output logic [4:0]         entry_count,
  output logic               has_element,
  output logic signed [31:0] element_value,
  output logic [3:0]         element_index,
  output logic               last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic        [31:0] store [DEPTH];
  logic               state;
  logic      [CW-1:0] count;
  logic      [IW-1:0] idx;
  logic      [IW-1:0] slot;
  logic               cur_err;
  logic         [1:0] cur_status;
  logic               load;
  logic               is_last;

  assign pop     = (state == S_IDLE) && q_valid;
  assign load    = (state == S_EMIT) && (!out_valid || out_ready);
  assign slot    = q_cmd.slot[IW-1:0];
  assign is_last = ((CW'(idx) + CW'(1)) == count);

  // entries past the slot (at or past it on delete) shift from a fixed neighbour
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (q_cmd.kind == pli_pkg::K_INS) begin
          if (IW'(i) == slot) begin
            store[i] <= q_cmd.value;
          end else if (i > 0 && IW'(i) > slot) begin
            store[i] <= store[(i > 0) ? i - 1 : 0];
          end
        end else if (q_cmd.kind == pli_pkg::K_DEL) begin
          if (i < DEPTH - 1 && IW'(i) >= slot) begin
            store[i] <= store[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            count <= CW'(q_cmd.count);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            if (cur_err || count == '0 || is_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_err    <= (q_cmd.kind == pli_pkg::K_ERR);
      cur_status <= q_cmd.status;
      idx        <= '0;
    end
    if (load) begin
      status      <= cur_err ? cur_status : pli_pkg::ST_OK;
      entry_count <= 5'(count);
      if (cur_err || count == '0) begin
        has_element   <= 1'b0;
        element_value <= '0;
        element_index <= '0;
        last          <= 1'b1;
      end else begin
        has_element   <= 1'b1;
        element_value <= store[idx];
        element_index <= 4'(idx);
        last          <= is_last;
        idx           <= idx + IW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/positional_list_insert_delete_top.sv @@
// top level of the positional list: front end, command queue and back end
//
// input channel (in_valid/in_ready) takes one request word: opcode, value,
// position. opcode 0 inserts before, 1 inserts after, 2 deletes at the
// one-based position; the first insert into an empty list goes to the head.
// output channel (out_valid/out_ready) gives the list head to tail, one word
// per element with last on the final one, a single empty marker when the
// list is empty, or a single error word (bad position, full, empty delete).
// a request is first written into the command queue; the back end then takes it,
// updates the shift array and emits its words in order, head to tail, and
// returns to idle after the last word, an error word or the empty marker.
// the front end checks requests against its own count and a two-entry
// command queue lets it take further requests while the back end emits.
// the output word is registered; a stalled receiver holds the back end,
// and the front end stops taking words once the queue is full.
// reset empties the list and the queue; stored values need no clearing.
`default_nettype none

module positional_list_insert_delete_top #(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         opcode,
  input  wire  signed [31:0] value,
  input  wire  [4:0]         position,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         status,
  output logic [4:0]         entry_count,
  output logic               has_element,
  output logic signed [31:0] element_value,
  output logic [3:0]         element_index,
  output logic               last
);

  logic          push;
  pli_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  logic          q_valid;
  pli_pkg::cmd_t q_cmd;

  pli_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .value    (value),
    .position (position),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pli_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  pli_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .entry_count   (entry_count),
    .has_element   (has_element),
    .element_value (element_value),
    .element_index (element_index),
    .last          (last)
  );

endmodule

`default_nettype wire
